// File: sv/b58enc_pkg.sv
// Shared types, constants and arithmetic helpers for the base58 encoder.
package b58enc_pkg;

  localparam int DIGIT_W = 6;
  localparam int BYTE_W = 8;
  localparam int SUM_W = DIGIT_W + BYTE_W;

  localparam int DEPTH_NUM = 138;
  localparam int DEPTH_DEN = 100;

  localparam int ALPHA_LEN = 58;
  localparam logic [ALPHA_LEN*8-1:0] ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
  localparam logic [BYTE_W-1:0] CHAR_ONE = 8'h31;

  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W = 15;
  localparam logic [RECIP_W-1:0] RECIP58 = 15'd18079;
  localparam int PROD_W = SUM_W + RECIP_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_FETCH,
    ST_TRIM,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_TOP,
    RD_NEXT,
    RD_BELOW
  } rd_sel_e;

  typedef struct packed {
    logic    take;
    logic    walk;
    logic    trim;
    logic    emit;
    logic    rd_en;
    rd_sel_e rd_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic draining;
    logic walk_go;
    logic last_in;
    logic walk_more;
    logic last_q;
    logic trim_zero;
    logic out_busy;
  } ctrl_sts_t;

  function automatic logic [BYTE_W-1:0] div58(input logic [SUM_W-1:0] x);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(x) * PROD_W'(RECIP58);
    return prod[RECIP_SHIFT +: BYTE_W];
  endfunction

  function automatic logic [BYTE_W-1:0] b58_char(input logic [DIGIT_W-1:0] digit);
    logic [BYTE_W-1:0] ch;
    ch = CHAR_ONE;
    if (int'(digit) < ALPHA_LEN) begin
      ch = ALPHABET[(ALPHA_LEN - 1 - int'(digit)) * 8 +: 8];
    end
    return ch;
  endfunction

endpackage

// File: sv/b58enc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module b58enc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 45
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/b58enc_ctrl.sv
// Sequencing state machine of the base58 encoder.
module b58enc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  b58enc_pkg::ctrl_sts_t  sts_i,
  output b58enc_pkg::ctrl_cmd_t  cmd_o
);

  b58enc_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= b58enc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    in_ready_o = 1'b0;
    cmd_o = '0;
    cmd_o.rd_sel = b58enc_pkg::RD_ZERO;
    unique case (state_q)
      b58enc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.rd_en = 1'b1;
          if (sts_i.draining) begin
            cmd_o.rd_sel = b58enc_pkg::RD_TOP;
            state_d = b58enc_pkg::ST_EMIT;
          end else begin
            cmd_o.take = 1'b1;
            priority if (sts_i.walk_go) begin
              state_d = b58enc_pkg::ST_WALK;
            end else if (sts_i.last_in) begin
              state_d = b58enc_pkg::ST_FETCH;
            end else begin
              state_d = b58enc_pkg::ST_IDLE;
            end
          end
        end
      end
      b58enc_pkg::ST_WALK: begin
        cmd_o.walk = 1'b1;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = b58enc_pkg::RD_NEXT;
        if (!sts_i.walk_more) begin
          state_d = sts_i.last_q ? b58enc_pkg::ST_FETCH : b58enc_pkg::ST_IDLE;
        end
      end
      b58enc_pkg::ST_FETCH: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = b58enc_pkg::RD_TOP;
        state_d = b58enc_pkg::ST_TRIM;
      end
      b58enc_pkg::ST_TRIM: begin
        if (sts_i.trim_zero) begin
          cmd_o.trim = 1'b1;
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = b58enc_pkg::RD_BELOW;
        end else if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d = b58enc_pkg::ST_IDLE;
        end
      end
      b58enc_pkg::ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d = b58enc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = b58enc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/b58enc_dpath.sv
// Digit store, base-58 carry walk and character output register.
module b58enc_dpath #(
  parameter int MAX_BYTES = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [b58enc_pkg::BYTE_W-1:0]     data_byte_i,
  input  logic                              end_of_message_i,
  input  b58enc_pkg::ctrl_cmd_t             cmd_i,
  output b58enc_pkg::ctrl_sts_t             sts_o,
  output logic [b58enc_pkg::BYTE_W-1:0]     char_code_o,
  output logic                              final_char_o,
  output logic                              overflow_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i
);

  localparam int DEPTH = MAX_BYTES * b58enc_pkg::DEPTH_NUM / b58enc_pkg::DEPTH_DEN + 1;
  localparam int AW = $clog2(DEPTH);
  localparam int IW = $clog2(DEPTH + 1);
  localparam int TW = $clog2(MAX_BYTES + 1);
  localparam int DW = b58enc_pkg::DIGIT_W;
  localparam int BW = b58enc_pkg::BYTE_W;
  localparam int SW = b58enc_pkg::SUM_W;

  logic [TW-1:0] taken_q, lz_q;
  logic [IW-1:0] used_q;
  logic          seen_q, ovf_q, draining_q, last_q, out_valid_q;
  logic [AW-1:0] idx_q;
  logic [BW-1:0] carry_q;
  logic [BW-1:0] char_q;
  logic          final_q, ovf_out_q;

  logic [DW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [IW-1:0] idx_ext, idx_nxt, used_m1, used_m2;
  logic [DW-1:0] digit;
  logic [SW-1:0] sum, rem_full;
  logic [BW-1:0] quot;
  logic [DW-1:0] rem;
  logic          walk_more, has_room;
  logic [TW-1:0] lz_e;
  logic [IW-1:0] used_e;
  logic [BW-1:0] emit_char;
  logic          emit_final;

  b58enc_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_digit_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.walk),
    .wr_addr_i (idx_q),
    .wr_data_i (rem),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    idx_ext = IW'(idx_q);
    idx_nxt = idx_ext + IW'(1);
    used_m1 = used_q - IW'(1);
    used_m2 = used_q - IW'(2);
    has_room = (taken_q < TW'(MAX_BYTES));

    // Entries at or above the fill count read as zero
    digit = (idx_ext < used_q) ? rd_data : '0;
    sum = {digit, {BW{1'b0}}} + SW'(carry_q);
    quot = b58enc_pkg::div58(sum);
    rem_full = sum - SW'({quot, 6'b0}) + SW'({quot, 2'b0}) + SW'({quot, 1'b0});
    rem = rem_full[DW-1:0];
    walk_more = ((quot != '0) || (idx_nxt < used_q)) && (idx_nxt < IW'(DEPTH));

    unique case (cmd_i.rd_sel)
      b58enc_pkg::RD_ZERO:  rd_addr = '0;
      b58enc_pkg::RD_TOP:   rd_addr = used_m1[AW-1:0];
      b58enc_pkg::RD_NEXT:  rd_addr = idx_nxt[AW-1:0];
      b58enc_pkg::RD_BELOW: rd_addr = used_m2[AW-1:0];
      default:              rd_addr = '0;
    endcase

    lz_e = lz_q;
    used_e = used_q;
    emit_char = b58enc_pkg::CHAR_ONE;
    if (lz_q != '0) begin
      lz_e = lz_q - TW'(1);
    end else if (used_q != '0) begin
      used_e = used_m1;
      emit_char = b58enc_pkg::b58_char(rd_data);
    end
    emit_final = (lz_e == '0) && (used_e == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= '0;
      lz_q <= '0;
      used_q <= '0;
      seen_q <= 1'b0;
      ovf_q <= 1'b0;
      draining_q <= 1'b0;
      last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        last_q <= end_of_message_i;
        if (has_room) begin
          taken_q <= taken_q + TW'(1);
          if (!seen_q && (data_byte_i == '0)) begin
            lz_q <= lz_q + TW'(1);
          end else begin
            seen_q <= 1'b1;
          end
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.walk && !walk_more) begin
        used_q <= idx_nxt;
      end
      if (cmd_i.trim) begin
        used_q <= used_m1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (emit_final) begin
          taken_q <= '0;
          lz_q <= '0;
          used_q <= '0;
          seen_q <= 1'b0;
          ovf_q <= 1'b0;
          draining_q <= 1'b0;
        end else begin
          lz_q <= lz_e;
          used_q <= used_e;
          draining_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      carry_q <= data_byte_i;
      idx_q <= '0;
    end
    if (cmd_i.walk) begin
      carry_q <= quot;
      idx_q <= idx_nxt[AW-1:0];
    end
    if (cmd_i.emit) begin
      char_q <= emit_char;
      final_q <= emit_final;
      ovf_out_q <= ovf_q;
    end
  end

  always_comb begin
    sts_o.draining = draining_q;
    sts_o.walk_go = has_room && (seen_q || (data_byte_i != '0));
    sts_o.last_in = end_of_message_i;
    sts_o.walk_more = walk_more;
    sts_o.last_q = last_q;
    sts_o.trim_zero = (used_q != '0) && (rd_data == '0);
    sts_o.out_busy = out_valid_q && !out_ready_i;
  end

  assign char_code_o = char_q;
  assign final_char_o = final_q;
  assign overflow_o = ovf_out_q;
  assign out_valid_o = out_valid_q;

endmodule

// File: sv/base58_encoder.sv
// Top level of the byte-serial base58 encoder.
// Feed a message one byte per input transaction, flagging the last byte with
// end_of_message_i; leading zero bytes become '1' characters and the rest of
// the message is kept as base-58 digits in a digit RAM of
// MAX_BYTES*138/100+1 entries. A leading zero byte is only counted; any other
// byte is folded in as the carry walks the digits in use (up to 45 at the
// default MAX_BYTES) in the digit RAM, one read and one write a cycle.
// After the last byte the top digit is fetched and high zero digits are
// trimmed before the first character is presented. Each further input
// transaction after that ignores its fields and yields the next character
// until final_char_o marks the end of the string; overflow_o is set on every
// character of a message that had bytes beyond MAX_BYTES, which are dropped.
// A waiting output transaction does not stop the next input being taken.
module base58_encoder #(
  parameter int MAX_BYTES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_message_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic [7:0] char_code_o,
  output logic       final_char_o,
  output logic       overflow_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  b58enc_pkg::ctrl_cmd_t cmd;
  b58enc_pkg::ctrl_sts_t sts;

  b58enc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  b58enc_dpath #(
    .MAX_BYTES (MAX_BYTES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .char_code_o      (char_code_o),
    .final_char_o     (final_char_o),
    .overflow_o       (overflow_o),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i)
  );

endmodule

// File: sv/b58enc_checker.sv
// Port-level checks for the base58 encoder, bound to the top level.
module b58enc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic [7:0] char_code_i,
  input logic       final_char_i,
  input logic       overflow_i,
  input logic       out_valid_i,
  input logic       out_ready_i
);

  // Hold a stalled output transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(char_code_i) && $stable(final_char_i) && $stable(overflow_i))
    else $error("output transaction changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (char_code_i >= 8'h31) && (char_code_i <= 8'h7a))
    else $error("character outside the base58 alphabet range");

  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("output valid after reset");

endmodule

bind base58_encoder b58enc_checker u_b58enc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .char_code_i  (char_code_o),
  .final_char_i (final_char_o),
  .overflow_i   (overflow_o),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i)
);

// File: verif/base58_encoder_test.sv
// Self-checking testbench for the byte-serial base58 encoder.
`timescale 1ns / 1ps

module base58_encoder_test;

  localparam int MAX_BYTES = 32;
  localparam int DIGITS = MAX_BYTES * b58enc_pkg::DEPTH_NUM / b58enc_pkg::DEPTH_DEN + 1;
  localparam int ITEM_TARGET = 1500;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 100;
  localparam logic [58*8-1:0] B58_DIGITS =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef enum logic [1:0] {
    EXP_MODEL,
    EXP_NONE,
    EXP_GIVEN
  } exp_kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       ovf;
  } enc_char_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
    exp_kind_e  kind;
    enc_char_t  given;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       end_of_message_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] char_code_o;
  logic       final_char_o;
  logic       overflow_o;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;

  base58_encoder #(
    .MAX_BYTES(MAX_BYTES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .data_byte_i     (data_byte_i),
    .end_of_message_i(end_of_message_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_code_o     (char_code_o),
    .final_char_o    (final_char_o),
    .overflow_o      (overflow_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i)
  );

  // Encoder state as seen from outside
  logic [5:0] b58_digits [DIGITS];
  logic [5:0] live_digits;
  logic [5:0] lead_zeros;
  logic       past_zeros;
  logic [5:0] bytes_kept;
  logic       bytes_dropped;
  logic       sending;

  enc_char_t  pending_chars [$];
  enc_char_t  want;
  int         errors = 0;
  int         items_sent = 0;
  int         burst_left = 0;
  int         cycle_count = 0;
  logic [31:0] stall_pattern = '1;
  logic [4:0]  stall_phase = '0;

  stim_row_t directed_rows [21] = '{
    '{8'h00, 1'b1, EXP_GIVEN, '{"1", 1'b1, 1'b0}},
    '{8'h01, 1'b1, EXP_GIVEN, '{"2", 1'b1, 1'b0}},
    '{8'h39, 1'b1, EXP_GIVEN, '{"z", 1'b1, 1'b0}},
    '{8'h3A, 1'b1, EXP_MODEL, '0},
    '{8'hFF, 1'b1, EXP_MODEL, '0},
    '{8'hFF, 1'b0, EXP_NONE,  '0},
    '{8'hFF, 1'b1, EXP_MODEL, '0},
    '{8'h00, 1'b0, EXP_MODEL, '0},
    '{8'hAA, 1'b1, EXP_MODEL, '0},
    '{8'h00, 1'b0, EXP_NONE,  '0},
    '{8'h00, 1'b0, EXP_NONE,  '0},
    '{8'h01, 1'b1, EXP_MODEL, '0},
    '{8'h55, 1'b0, EXP_MODEL, '0},
    '{8'hFF, 1'b1, EXP_MODEL, '0},
    '{8'h00, 1'b0, EXP_NONE,  '0},
    '{8'h00, 1'b1, EXP_MODEL, '0},
    '{8'h7F, 1'b1, EXP_MODEL, '0},
    '{8'h80, 1'b0, EXP_NONE,  '0},
    '{8'h00, 1'b1, EXP_MODEL, '0},
    '{8'h01, 1'b0, EXP_MODEL, '0},
    '{8'hFE, 1'b1, EXP_MODEL, '0}
  };

  function automatic void clear_encoder();
    foreach (b58_digits[i]) b58_digits[i] = '0;
    live_digits = '0;
    lead_zeros = '0;
    past_zeros = 1'b0;
    bytes_kept = '0;
    bytes_dropped = 1'b0;
    sending = 1'b0;
  endfunction

  function automatic void fold_byte(input logic [7:0] b);
    int carry;
    int i;
    carry = int'(b);
    i = 0;
    if (!past_zeros && b == 8'h00) begin
      lead_zeros++;
      return;
    end
    past_zeros = 1'b1;
    while ((carry != 0 || i < int'(live_digits)) && i < DIGITS) begin
      carry = carry + 256 * int'(b58_digits[i]);
      b58_digits[i] = 6'(carry % 58);
      carry = carry / 58;
      i++;
    end
    live_digits = 6'(i);
  endfunction

  function automatic enc_char_t next_char();
    enc_char_t r;
    int d;
    r.ovf = bytes_dropped;
    r.ch = "1";
    if (lead_zeros != 0) begin
      lead_zeros--;
    end else if (live_digits != 0) begin
      d = int'(b58_digits[live_digits - 1]);
      live_digits--;
      r.ch = B58_DIGITS[(57 - d) * 8 +: 8];
    end
    r.fin = (lead_zeros == 0 && live_digits == 0);
    if (r.fin) clear_encoder();
    return r;
  endfunction

  function automatic void encode_step(input logic [7:0] b, input logic eom,
                                      output logic got, output enc_char_t r);
    got = 1'b0;
    r = '0;
    if (sending) begin
      r = next_char();
      got = 1'b1;
      return;
    end
    if (bytes_kept < MAX_BYTES) begin
      bytes_kept++;
      fold_byte(b);
    end else begin
      bytes_dropped = 1'b1;
    end
    if (!eom) return;
    while (live_digits != 0 && b58_digits[live_digits - 1] == '0) live_digits--;
    sending = 1'b1;
    r = next_char();
    got = 1'b1;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(input stim_row_t row);
    logic got;
    enc_char_t res;
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
                                                 $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= row.data;
    end_of_message_i <= row.eom;
    do @(posedge clk_i); while (!in_ready_o);
    encode_step(row.data, row.eom, got, res);
    case (row.kind)
      EXP_GIVEN: pending_chars.push_back(row.given);
      EXP_MODEL: if (got) pending_chars.push_back(res);
      default: ;
    endcase
    burst_left--;
    items_sent++;
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk_i);
  endtask

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (stall_phase == '0) begin
      case ($urandom_range(0, 3))
        0: stall_pattern = '1;
        1: stall_pattern = $urandom;
        2: stall_pattern = $urandom & $urandom;
        default: stall_pattern = $urandom | $urandom;
      endcase
    end
    out_ready_i <= stall_pattern[stall_phase];
    stall_phase = stall_phase + 5'd1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: char_code %0h", char_code_o);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        if (char_code_o !== want.ch) begin
          $error("char_code: expected %0h, got %0h", want.ch, char_code_o);
          errors++;
        end
        if (final_char_o !== want.fin) begin
          $error("final_char: expected %0b, got %0b", want.fin, final_char_o);
          errors++;
        end
        if (overflow_o !== want.ovf) begin
          $error("overflow: expected %0b, got %0b", want.ovf, overflow_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int len;
    int zeros;
    stim_row_t row;
    clear_encoder();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_rows[i]) send_item(directed_rows[i]);
    pause_until_drained();
    row = '0;
    row.kind = EXP_MODEL;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 15)) inside
        [0:9]:   len = $urandom_range(1, 6);
        [10:13]: len = $urandom_range(7, MAX_BYTES);
        default: len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 8);
      endcase
      zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : 0;
      for (int i = 0; i < len; i++) begin
        row.data = (i < zeros) ? 8'h00 : pick_byte();
        row.eom = (i == len - 1);
        send_item(row);
      end
      while (sending) begin
        row.data = 8'($urandom);
        row.eom = 1'($urandom);
        send_item(row);
      end
      if ($urandom_range(0, 19) == 0) pause_until_drained();
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/b58enc_pkg.sv
sv/b58enc_ram.sv
sv/b58enc_ctrl.sv
sv/b58enc_dpath.sv
sv/base58_encoder.sv
sv/b58enc_checker.sv
verif/base58_encoder_test.sv
